// ===== design/assert_macros.svh =====
// Assertion macros used by the queue controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SPQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define SPQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
// Types and constants for the sorted priority task queue.
package spq_pkg;

  localparam int ID_W         = 16;
  localparam int PRI_W        = 8;
  localparam int DEF_CAPACITY = 16;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_LIST   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_LIST,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic             last;
  } res_t;

endpackage

// ===== design/sorted_priority_task_queue.sv =====
// Insert: a scan reads one entry per cycle to find the slot, then a shift moves one entry
// per cycle through the entry store; a duplicate id or a full queue ends after the scan.
// Pop and remove: scan for the entry, then shift later entries down; an empty queue skips both.
// List: entries go out in order, one entry per cycle while the output is free.
// Accept the next request in the cycle after the result is loaded; a busy output stalls.
// Reset empties the queue and output; the store itself is not cleared.
module sorted_priority_task_queue import spq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [15:0] task_id, [23:16] task_priority
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] out_id, [23:16] out_priority
  output logic [2:0]  m_axis_tuser,  // [2:0] status
  output logic        m_axis_tlast   // last
);

  localparam int AW = $clog2(CAPACITY);

  logic          out_free;
  logic          res_load;
  res_t          res;
  res_t          out_q;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  entry_t        rdata;

  spq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_req   (req_t'(s_axis_tuser)),
    .in_id    (s_axis_tdata[15:0]),
    .in_pri   (s_axis_tdata[23:16]),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  spq_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = {out_q.pri, out_q.id};
  assign m_axis_tuser = out_q.status;
  assign m_axis_tlast = out_q.last;

endmodule

// ===== design/spq_mem.sv =====
// Entry store: one write port, one registered read port.
module spq_mem import spq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/spq_ctrl.sv =====
// Request sequencer: scans, shifts and lists entries through the store.
`include "assert_macros.svh"

module spq_ctrl import spq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_req,
  input  logic [ID_W-1:0]  in_id,
  input  logic [PRI_W-1:0] in_pri,
  input  logic             out_free,
  output logic             res_load,
  output res_t             res,
  output logic             we,
  output logic [AW-1:0]    waddr,
  output entry_t           wdata,
  output logic [AW-1:0]    raddr,
  input  entry_t           rdata
);

  state_t         state, state_next;
  logic [CW-1:0]  count, count_next;
  req_t           req, req_next;
  entry_t         key, key_next;
  logic [CW-1:0]  idx, idx_next;
  logic [CW-1:0]  pos, pos_next;
  logic           pos_found, pos_found_next;
  logic           d_vld, d_vld_next;
  logic [CW-1:0]  d_idx, d_idx_next;
  res_t           rsp, rsp_next;

  logic           hit_id;
  logic           lower;
  logic           tail;
  logic           match;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      d_vld <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      d_vld <= d_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    req       <= req_next;
    key       <= key_next;
    idx       <= idx_next;
    pos       <= pos_next;
    pos_found <= pos_found_next;
    d_idx     <= d_idx_next;
    rsp       <= rsp_next;
  end

  assign hit_id = (rdata.id == key.id);
  assign lower  = (rdata.pri < key.pri);
  assign tail   = (d_idx == count - CW'(1));
  assign match  = (req == REQ_POP) ? (d_idx == '0) : hit_id;

  always_comb begin
    state_next     = state;
    count_next     = count;
    req_next       = req;
    key_next       = key;
    idx_next       = idx;
    pos_next       = pos;
    pos_found_next = pos_found;
    d_vld_next     = d_vld;
    d_idx_next     = d_idx;
    rsp_next       = rsp;
    in_ready       = 1'b0;
    res_load       = 1'b0;
    res            = rsp;
    we             = 1'b0;
    waddr          = '0;
    wdata          = key;
    raddr          = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_next       = in_req;
          key_next       = '{id: in_id, pri: in_pri};
          pos_found_next = 1'b0;
          d_vld_next     = 1'b0;
          d_idx_next     = '0;
          idx_next       = CW'(1);
          case (in_req)
            REQ_INSERT: begin
              if (count == '0) begin
                pos_next   = '0;
                idx_next   = '0;
                state_next = S_SHIFT_UP;
              end else begin
                d_vld_next = 1'b1;
                state_next = S_SCAN;
              end
            end
            REQ_POP, REQ_REMOVE: begin
              if (count == '0) begin
                rsp_next   = '{status: (in_req == REQ_POP) ? ST_EMPTY : ST_NOTFOUND,
                               id: '0, pri: '0, last: 1'b1};
                state_next = S_RESP;
              end else begin
                d_vld_next = 1'b1;
                state_next = S_SCAN;
              end
            end
            default: begin
              if (count == '0) begin
                rsp_next   = '{status: ST_EMPTY, id: '0, pri: '0, last: 1'b1};
                state_next = S_RESP;
              end else begin
                state_next = S_LIST;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        raddr = idx[AW-1:0];
        if (idx < count) begin
          idx_next   = idx + CW'(1);
          d_vld_next = 1'b1;
          d_idx_next = idx;
        end else begin
          d_vld_next = 1'b0;
        end
        if (d_vld) begin
          if (req == REQ_INSERT) begin
            if (hit_id) begin
              rsp_next   = '{status: ST_DUP, id: '0, pri: '0, last: 1'b1};
              d_vld_next = 1'b0;
              state_next = S_RESP;
            end else begin
              if (!pos_found && lower) begin
                pos_found_next = 1'b1;
                pos_next       = d_idx;
              end
              if (tail) begin
                d_vld_next = 1'b0;
                if (count == CW'(CAPACITY)) begin
                  rsp_next   = '{status: ST_FULL, id: '0, pri: '0, last: 1'b1};
                  state_next = S_RESP;
                end else begin
                  pos_next   = pos_found ? pos : (lower ? d_idx : count);
                  idx_next   = count;
                  state_next = S_SHIFT_UP;
                end
              end
            end
          end else begin
            if (match) begin
              rsp_next   = '{status: ST_OK, id: rdata.id, pri: rdata.pri, last: 1'b1};
              pos_next   = d_idx;
              idx_next   = d_idx + CW'(1);
              d_vld_next = 1'b0;
              state_next = S_SHIFT_DN;
            end else if (tail) begin
              rsp_next   = '{status: ST_NOTFOUND, id: '0, pri: '0, last: 1'b1};
              d_vld_next = 1'b0;
              state_next = S_RESP;
            end
          end
        end
      end
      S_SHIFT_UP: begin
        if (d_vld) begin
          we    = 1'b1;
          waddr = AW'(d_idx + CW'(1));
          wdata = rdata;
        end
        if (idx > pos) begin
          raddr      = AW'(idx - CW'(1));
          d_vld_next = 1'b1;
          d_idx_next = idx - CW'(1);
          idx_next   = idx - CW'(1);
        end else begin
          d_vld_next = 1'b0;
          if (!d_vld) begin
            we         = 1'b1;
            waddr      = pos[AW-1:0];
            wdata      = key;
            count_next = count + CW'(1);
            rsp_next   = '{status: ST_OK, id: '0, pri: '0, last: 1'b1};
            state_next = S_RESP;
          end
        end
      end
      S_SHIFT_DN: begin
        if (d_vld) begin
          we    = 1'b1;
          waddr = AW'(d_idx - CW'(1));
          wdata = rdata;
        end
        if (idx < count) begin
          raddr      = idx[AW-1:0];
          d_vld_next = 1'b1;
          d_idx_next = idx;
          idx_next   = idx + CW'(1);
        end else begin
          d_vld_next = 1'b0;
          if (!d_vld) begin
            count_next = count - CW'(1);
            state_next = S_RESP;
          end
        end
      end
      S_LIST: begin
        raddr = d_idx[AW-1:0];
        if (out_free) begin
          res_load = 1'b1;
          res      = '{status: ST_OK, id: rdata.id, pri: rdata.pri, last: tail};
          if (tail) begin
            state_next = S_IDLE;
          end else begin
            raddr      = AW'(d_idx + CW'(1));
            d_idx_next = d_idx + CW'(1);
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          res_load   = 1'b1;
          res        = rsp;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `SPQ_ASSERT(a_count_range, clk, rst, count <= CW'(CAPACITY), "entry count above capacity")
  `SPQ_ASSERT_IMPL(a_load_free, clk, rst, res_load, out_free, "result loaded into busy output")
  `SPQ_ASSERT_IMPL(a_write_range, clk, rst, we, CW'(waddr) <= count, "write beyond stored entries")
  `SPQ_ASSERT_IMPL(a_count_step, clk, rst, count != $past(count), $past(state) == S_SHIFT_UP || $past(state) == S_SHIFT_DN, "count changed outside a shift")

endmodule
